/* design/dstwr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dstwr_pkg
// Shared types for the DS-TWR time-of-flight unit: input and result items.
// ----------------------------------------------------------------------------
package dstwr_pkg;

    // Width of every timestamp field on the port
    localparam int STAMP_PORT_BITS = 32;
    // Width of the signed flight time
    localparam int FLIGHT_BITS     = 33;

    // One set of ranging timestamps
    typedef struct packed {
        logic [STAMP_PORT_BITS-1:0] local_poll_rx;
        logic [STAMP_PORT_BITS-1:0] local_resp_tx;
        logic [STAMP_PORT_BITS-1:0] local_final_rx;
        logic [STAMP_PORT_BITS-1:0] remote_poll_tx;
        logic [STAMP_PORT_BITS-1:0] remote_resp_rx;
        logic [STAMP_PORT_BITS-1:0] remote_final_tx;
    } t_tof_in;

    // One ranging result
    typedef struct packed {
        logic signed [FLIGHT_BITS-1:0] flight_time;
        logic                          zero_divisor;
    } t_tof_out;

endpackage

/* design/ds_twr_time_of_flight_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ds_twr_time_of_flight_unit
// Asymmetric double-sided two-way ranging: (Ra*Rb - Da*Db)/(Ra+Rb+Da+Db).
// ----------------------------------------------------------------------------
// A timestamp set is taken on every cycle with start high; busy never rises.
// Each set gives one result, shown for one cycle with o_strobe, once it
// has passed stages 1 to 3, the divider stages and the output register.
// The restoring divider gives one quotient bit per pipeline stage. The
// receiver cannot stall the result, and none is needed: the pipeline
// never stops.
module ds_twr_time_of_flight_unit
    import dstwr_pkg::*;
#(
    parameter int STAMP_BITS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_tof_in  i_item,
    output logic     o_strobe,
    output t_tof_out o_result
);

    localparam int SB = STAMP_BITS;
    localparam int PB = 2 * SB;       // product and quotient width
    localparam int DW = SB + 2;       // divisor and remainder width
    localparam int NQ = PB;           // divider stages

    // ---------------- stage 1: intervals and divisor ----------------
    logic [SB-1:0] lpr, ltx, lfr, rpt, rrr, rft;
    assign lpr = SB'(i_item.local_poll_rx);
    assign ltx = SB'(i_item.local_resp_tx);
    assign lfr = SB'(i_item.local_final_rx);
    assign rpt = SB'(i_item.remote_poll_tx);
    assign rrr = SB'(i_item.remote_resp_rx);
    assign rft = SB'(i_item.remote_final_tx);

    logic          r_v1;
    logic [SB-1:0] r_ra, r_rb, r_da, r_db;
    logic [DW-1:0] r_sum1;
    logic [SB-1:0] n_ra, n_rb, n_da, n_db;

    assign n_ra = rrr - rpt;
    assign n_rb = lfr - ltx;
    assign n_da = rft - rrr;
    assign n_db = ltx - lpr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start;
        end
        r_ra   <= n_ra;
        r_rb   <= n_rb;
        r_da   <= n_da;
        r_db   <= n_db;
        r_sum1 <= DW'(n_ra) + DW'(n_rb) + DW'(n_da) + DW'(n_db);
    end

    // ---------------- stage 2: the two products ----------------
    logic          r_v2;
    logic [PB-1:0] r_pab, r_pdd;
    logic [DW-1:0] r_sum2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_pab  <= PB'(r_ra) * PB'(r_rb);
        r_pdd  <= PB'(r_da) * PB'(r_db);
        r_sum2 <= r_sum1;
    end

    // ---------------- stage 3: signed difference as sign and magnitude ----------------
    logic          r_v3;
    logic [PB-1:0] r_mag3;
    logic          r_neg3;
    logic          r_zero3;
    logic [DW-1:0] r_sum3;
    logic          ge;

    assign ge = (r_pab >= r_pdd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_mag3  <= ge ? (r_pab - r_pdd) : (r_pdd - r_pab);
        r_neg3  <= !ge;
        r_zero3 <= (r_sum2 == '0);
        r_sum3  <= r_sum2;
    end

    // ---------------- divider: one restoring step per stage ----------------
    logic          r_dv   [0:NQ];
    logic [PB-1:0] r_num  [0:NQ];
    logic [PB-1:0] r_quo  [0:NQ];
    logic [DW-1:0] r_rem  [0:NQ];
    logic [DW-1:0] r_den  [0:NQ];
    logic          r_dneg [0:NQ];
    logic          r_dzero[0:NQ];

    assign r_dv[0]    = r_v3;
    assign r_num[0]   = r_mag3;
    assign r_quo[0]   = '0;
    assign r_rem[0]   = '0;
    assign r_den[0]   = r_sum3;
    assign r_dneg[0]  = r_neg3;
    assign r_dzero[0] = r_zero3;

    for (genvar k = 0; k < NQ; k++) begin : g_div
        logic [DW:0] rem_sh;
        logic        take;

        assign rem_sh = {r_rem[k], r_num[k][PB-1]};
        assign take   = (rem_sh >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else begin
                r_dv[k+1] <= r_dv[k];
            end
            r_num[k+1]   <= {r_num[k][PB-2:0], 1'b0};
            r_quo[k+1]   <= {r_quo[k][PB-2:0], take};
            r_rem[k+1]   <= take ? DW'(rem_sh - {1'b0, r_den[k]}) : DW'(rem_sh);
            r_den[k+1]   <= r_den[k];
            r_dneg[k+1]  <= r_dneg[k];
            r_dzero[k+1] <= r_dzero[k];
        end
    end

    // ---------------- output: saturate, apply sign, zero on a zero divisor, register ----------------
    logic [31:0]            mag_sat;
    logic [FLIGHT_BITS-1:0] n_flight;
    logic                   r_strobe;
    t_tof_out               r_out;

    // Quotient above the 32-bit magnitude range clips to the maximum
    assign mag_sat  = (r_quo[NQ] > PB'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : r_quo[NQ][31:0];
    assign n_flight = r_dzero[NQ] ? '0 :
                      (r_dneg[NQ] ? (FLIGHT_BITS'(0) - {1'b0, mag_sat}) : {1'b0, mag_sat});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_dv[NQ];
        end
        r_out.flight_time  <= n_flight;
        r_out.zero_divisor <= r_dzero[NQ];
    end

    assign busy     = 1'b0;
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // ---------------- checks ----------------
    a_zero_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.zero_divisor |-> o_result.flight_time == '0)
        else $error("zero divisor with nonzero flight time");

    a_strobe_from_divider: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv[NQ] |=> o_strobe)
        else $error("divider output lost");

    a_stage1_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> r_v1)
        else $error("accepted set not tracked in stage 1");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv[NQ] && !r_dzero[NQ] |-> r_rem[NQ] < r_den[NQ])
        else $error("divider remainder out of range");

endmodule
